/* hdl/pmfb_pkg.sv */
// ----------------------------------------------------------------------------
// pmfb_pkg
// Shared types, constants and helper functions for the Manchester frame
// builder: preamble table, parity and Manchester coding, inter-module structs.
// ----------------------------------------------------------------------------
`default_nettype none

package pmfb_pkg;

  // Field widths of one request.
  localparam int unsigned VersionW = 2;
  localparam int unsigned IdW      = 27;
  localparam int unsigned ValueW   = 20;
  localparam int unsigned StatusW  = 10;

  // Payload and frame geometry.
  localparam int unsigned PayloadW   = 49;
  localparam int unsigned GroupW     = 7;
  localparam int unsigned NumGroups  = 7;
  localparam int unsigned FrameBytes = 9;
  localparam int unsigned FrameW     = 8 * FrameBytes;
  localparam int unsigned NumNibbles = 2 * FrameBytes;

  // Output sequencing: preamble bytes, then one coded byte per nibble.
  localparam int unsigned PreambleLen = 10;
  localparam int unsigned FrameLen    = PreambleLen + NumNibbles;
  localparam int unsigned IdxW        = 5;
  localparam int unsigned PreIdxW     = 4;

  localparam logic [IdxW-1:0] LastIdx     = IdxW'(FrameLen - 1);
  localparam logic [IdxW-1:0] PreambleEnd = IdxW'(PreambleLen);

  // Filler used in status frames around the status flags.
  localparam logic [4:0] StatusLeadOnes  = 5'h1f;
  localparam logic [4:0] StatusTailZeros = 5'h00;

  // Frame handed from the input buffer to the serialiser.
  typedef struct packed {
    logic              valid;
    logic [FrameW-1:0] frame;
  } pmfb_frame_t;

  // Serialiser status reported back to the top level.
  typedef struct packed {
    logic            take;
    logic            active;
    logic [IdxW-1:0] idx;
  } pmfb_ser_status_t;

  // Fixed preamble sent ahead of every coded frame.
  function automatic logic [7:0] preamble_byte(input logic [PreIdxW-1:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'he1;
      4'd1:    b = 8'h1a;
      4'd2:    b = 8'h03;
      4'd9:    b = 8'h5a;
      default: b = 8'h55;
    endcase
    return b;
  endfunction

  // Seven data bits followed by an even parity bit.
  function automatic logic [7:0] parity_byte(input logic [GroupW-1:0] group);
    return {group, ^group};
  endfunction

  // Manchester code of one nibble, MSB first: a one becomes 01, a zero 10.
  function automatic logic [7:0] manchester_nibble(input logic [3:0] nib);
    logic [7:0] code;
    code = '0;
    for (int k = 0; k < 4; k++) begin
      code[2*k +: 2] = nib[k] ? 2'b01 : 2'b10;
    end
    return code;
  endfunction

endpackage : pmfb_pkg

`default_nettype wire

/* hdl/pmfb_if.sv */
// ----------------------------------------------------------------------------
// pmfb_if
// Valid/ready channels of the frame builder: the request channel and the
// byte stream channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface pmfb_req_if;
  import pmfb_pkg::*;

  logic                valid;
  logic                ready;
  logic                mode;
  logic [VersionW-1:0] version;
  logic [IdW-1:0]      meter_id;
  logic [ValueW-1:0]   meter_value;
  logic [StatusW-1:0]  status;

  modport source (output valid, mode, version, meter_id, meter_value, status,
                  input ready);
  modport sink   (input valid, mode, version, meter_id, meter_value, status,
                  output ready);
endinterface : pmfb_req_if

interface pmfb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last;

  modport source (output valid, tx_byte, last, input ready);
  modport sink   (input valid, tx_byte, last, output ready);
endinterface : pmfb_byte_if

`default_nettype wire

/* hdl/pmfb_encoder.sv */
// ----------------------------------------------------------------------------
// pmfb_encoder
// Builds the 49-bit payload from one request, cuts it into seven parity
// bytes and appends the column parity byte twice.
// ----------------------------------------------------------------------------
`default_nettype none

module pmfb_encoder
  import pmfb_pkg::*;
(
  input  wire logic                mode_i,
  input  wire logic [VersionW-1:0] version_i,
  input  wire logic [IdW-1:0]      meter_id_i,
  input  wire logic [ValueW-1:0]   meter_value_i,
  input  wire logic [StatusW-1:0]  status_i,
  output logic      [FrameW-1:0]   frame_o
);

  logic [PayloadW-1:0] payload;
  logic [7:0]          rows [NumGroups];
  logic [7:0]          col;

  // Reading frames carry the pulse count, status frames the flags.
  always_comb begin
    if (mode_i) begin
      payload = {version_i, meter_id_i, StatusLeadOnes, status_i, StatusTailZeros};
    end else begin
      payload = {version_i, meter_id_i, meter_value_i};
    end
  end

  // Row parity per group, column parity over all rows.
  always_comb begin
    col = '0;
    for (int n = 0; n < NumGroups; n++) begin
      rows[n] = parity_byte(payload[PayloadW-1-GroupW*n -: GroupW]);
      col     = col ^ rows[n];
    end
  end

  assign frame_o = {rows[0], rows[1], rows[2], rows[3], rows[4], rows[5], rows[6],
                    col, col};

endmodule : pmfb_encoder

`default_nettype wire

/* hdl/pmfb_serializer.sv */
// ----------------------------------------------------------------------------
// pmfb_serializer
// Walks one frame out as 28 bytes: the preamble, then one Manchester coded
// byte per frame nibble, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pmfb_serializer
  import pmfb_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire pmfb_frame_t      frame_i,
  output pmfb_ser_status_t      status_o,
  pmfb_byte_if.source           out_o
);

  logic [FrameW-1:0] frame_q;
  logic [IdxW-1:0]   idx_q;
  logic              active_q;
  logic              out_valid_q;
  logic [7:0]        out_byte_q;
  logic              out_last_q;

  logic              adv;
  logic              done;
  logic              take;
  logic [IdxW-1:0]   nib_idx;
  logic [3:0]        nibs [NumNibbles];
  logic [7:0]        next_byte;

  // A byte moves on when the output register is free or being drained.
  assign adv  = active_q && (!out_valid_q || out_o.ready);
  assign done = adv && (idx_q == LastIdx);
  assign take = frame_i.valid && (!active_q || done);

  // Select the next byte: preamble first, then coded nibbles.
  assign nib_idx = idx_q - PreambleEnd;

  always_comb begin
    for (int j = 0; j < NumNibbles; j++) begin
      nibs[j] = frame_q[FrameW-1-4*j -: 4];
    end
    if (idx_q < PreambleEnd) begin
      next_byte = preamble_byte(idx_q[PreIdxW-1:0]);
    end else begin
      next_byte = manchester_nibble(nibs[nib_idx]);
    end
  end

  // Frame holding register and byte counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
    end else if (take) begin
      active_q <= 1'b1;
      idx_q    <= '0;
    end else if (done) begin
      active_q <= 1'b0;
    end else if (adv) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      frame_q <= frame_i.frame;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_q <= next_byte;
      out_last_q <= (idx_q == LastIdx);
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.tx_byte = out_byte_q;
  assign out_o.last    = out_last_q;

  assign status_o.take   = take;
  assign status_o.active = active_q;
  assign status_o.idx    = idx_q;

endmodule : pmfb_serializer

`default_nettype wire

/* hdl/parity_manchester_frame_builder.sv */
// ----------------------------------------------------------------------------
// parity_manchester_frame_builder
// Turns one request into a 28-byte radio frame: fixed preamble followed by
// the Manchester coded payload with row and column parity.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Transfer carries
//  in_i     sink       mode, version, meter_id, meter_value, status
//  out_o    source     tx_byte, last (last on the 28th byte)
//
//  Each request yields 28 byte transfers, one per cycle when out_o is ready;
//  the byte counter sets the pace at which new requests are taken.
//  The encoded frame waits in a one-deep buffer, so the next request is taken
//  while the current frame is still being sent.
//  Reset clears the buffer, counter and output valid; stalls on out_o hold
//  the output byte and pause the counter.
// ----------------------------------------------------------------------------
`default_nettype none

module parity_manchester_frame_builder
  import pmfb_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pmfb_req_if.sink    in_i,
  pmfb_byte_if.source out_o
);

  logic              buf_valid_q;
  logic [FrameW-1:0] buf_frame_q;
  logic [FrameW-1:0] enc_frame;
  logic              in_xfer;
  pmfb_frame_t       ser_frame;
  pmfb_ser_status_t  ser_status;

  // Parity and layout of the incoming request.
  pmfb_encoder u_encoder (
    .mode_i        (in_i.mode),
    .version_i     (in_i.version),
    .meter_id_i    (in_i.meter_id),
    .meter_value_i (in_i.meter_value),
    .status_i      (in_i.status),
    .frame_o       (enc_frame)
  );

  // One-deep frame buffer in front of the serialiser.
  assign in_i.ready = !buf_valid_q || ser_status.take;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
    end else if (in_xfer) begin
      buf_valid_q <= 1'b1;
    end else if (ser_status.take) begin
      buf_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      buf_frame_q <= enc_frame;
    end
  end

  assign ser_frame.valid = buf_valid_q;
  assign ser_frame.frame = buf_frame_q;

  // Byte sequencer and output register.
  pmfb_serializer u_serializer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .frame_i  (ser_frame),
    .status_o (ser_status),
    .out_o    (out_o)
  );

  // A request transfer never overwrites a buffered frame that is not taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> (!buf_valid_q || ser_status.take))
    else $error("request transfer overwrote a pending frame");

  // A taken frame starts at the first preamble byte.
  a_take_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_status.take |=> (ser_status.active && ser_status.idx == '0))
    else $error("frame load did not restart the byte counter");

  // The byte counter never runs past the last byte of a frame.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_status.active |-> (ser_status.idx <= LastIdx))
    else $error("byte counter out of range");

  // A last byte that is sent leaves the serialiser idle or reloaded.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last) |->
      (!ser_status.active || ser_status.idx <= IdxW'(1)))
    else $error("last byte sent while frame still running");

endmodule : parity_manchester_frame_builder

`default_nettype wire
